>>> rtl/msta_pkg.sv
// ----------------------------------------------------------------------------
// msta_pkg - shared types and constants for the Morton swizzle address unit
// Field widths, register indexes, pixel size codes and the config bundle.
// ----------------------------------------------------------------------------
package msta_pkg;

    localparam int COORD_W = 12;  // texel coordinate width
    localparam int INDEX_W = 36;  // element index width
    localparam int PIXEL_W = 64;  // widest pixel
    localparam int LOG2_W  = 4;   // width of a log2 dimension register
    localparam int CFG_IDX_W = 3; // register index width
    localparam int CFG_DATA_W = 4; // register write data width

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LOG2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE  = 3'd4;

    // Pixel size codes
    localparam logic [1:0] PIX_8  = 2'd0;
    localparam logic [1:0] PIX_16 = 2'd1;
    localparam logic [1:0] PIX_32 = 2'd2;
    localparam logic [1:0] PIX_64 = 2'd3;

    typedef struct packed {
        logic [LOG2_W-1:0] width_log2;
        logic [LOG2_W-1:0] height_log2;
        logic [LOG2_W-1:0] depth_log2;
        logic              reverse_direction;
        logic [1:0]        pixel_size_code;
    } cfg_t;

endpackage

>>> rtl/msta_addr_calc.sv
// ----------------------------------------------------------------------------
// msta_addr_calc - linear / Morton index and pixel mask logic
// Pure combinational: one texel request in, source and destination index out.
// ----------------------------------------------------------------------------
module msta_addr_calc #(
    parameter int MAX_DIM_LOG2 = 12
) (
    input  msta_pkg::cfg_t                    cfg,
    input  logic [msta_pkg::COORD_W-1:0]      coord_x,
    input  logic [msta_pkg::COORD_W-1:0]      coord_y,
    input  logic [msta_pkg::COORD_W-1:0]      coord_z,
    input  logic [msta_pkg::PIXEL_W-1:0]      pixel_in,
    output logic [msta_pkg::INDEX_W-1:0]      source_index,
    output logic [msta_pkg::INDEX_W-1:0]      dest_index,
    output logic [msta_pkg::PIXEL_W-1:0]      pixel_out
);

    // Registers are 4 bits wide, so the cap can never exceed 15.
    localparam int DIM_CAP_INT = (MAX_DIM_LOG2 > 15) ? 15 : MAX_DIM_LOG2;
    localparam logic [msta_pkg::LOG2_W-1:0] DIM_CAP = DIM_CAP_INT[msta_pkg::LOG2_W-1:0];
    localparam int LIN_W  = msta_pkg::COORD_W + 2 * DIM_CAP_INT;
    localparam int WORK_W = (LIN_W > msta_pkg::INDEX_W) ? LIN_W : msta_pkg::INDEX_W;
    localparam int OUT_W  = msta_pkg::INDEX_W;

    function automatic logic [WORK_W-1:0] low_mask(input logic [5:0] n);
        return ~({WORK_W{1'b1}} << n);
    endfunction

    // 2D Z-order, x bit below y bit at each level
    function automatic logic [OUT_W-1:0] il2(input logic [WORK_W-1:0] a,
                                             input logic [WORK_W-1:0] b);
        logic [OUT_W-1:0] r;
        r = '0;
        for (int j = 0; j < OUT_W; j++) begin
            if ((j / 2) < MAX_DIM_LOG2) begin
                r[j] = ((j % 2) == 0) ? a[j / 2] : b[j / 2];
            end
        end
        return r;
    endfunction

    // 3D Morton: x at 3i, y at 3i+1, z at 3i+2
    function automatic logic [OUT_W-1:0] il3(input logic [WORK_W-1:0] a,
                                             input logic [WORK_W-1:0] b,
                                             input logic [WORK_W-1:0] c);
        logic [OUT_W-1:0] r;
        r = '0;
        for (int j = 0; j < OUT_W; j++) begin
            if ((j / 3) < MAX_DIM_LOG2 && (j / 3) < 21) begin
                case (j % 3)
                    0:       r[j] = a[j / 3];
                    1:       r[j] = b[j / 3];
                    default: r[j] = c[j / 3];
                endcase
            end
        end
        return r;
    endfunction

    logic [msta_pkg::LOG2_W-1:0] wl, hl, dl, he;
    logic [5:0]        wl6, hl6, dl6, he6, sb;
    logic [WORK_W-1:0] x, y, z, lin, swz, r, m, xs, ys, zs;

    always_comb begin
        wl = (cfg.width_log2  > DIM_CAP) ? DIM_CAP : cfg.width_log2;
        hl = (cfg.height_log2 > DIM_CAP) ? DIM_CAP : cfg.height_log2;
        dl = (cfg.depth_log2  > DIM_CAP) ? DIM_CAP : cfg.depth_log2;
        he = (hl > wl) ? wl : hl;
        wl6 = {2'b00, wl};
        hl6 = {2'b00, hl};
        dl6 = {2'b00, dl};
        he6 = {2'b00, he};

        // coordinates wrap modulo their dimension; z ignored in 2D
        x = {{(WORK_W - msta_pkg::COORD_W){1'b0}}, coord_x} & low_mask(wl6);
        y = {{(WORK_W - msta_pkg::COORD_W){1'b0}}, coord_y} & low_mask(hl6);
        z = (dl == '0) ? '0
            : ({{(WORK_W - msta_pkg::COORD_W){1'b0}}, coord_z} & low_mask(dl6));

        lin = x | (y << wl6) | (z << (wl6 + hl6));

        sb = '0;
        m  = '0;
        r  = '0;
        xs = '0;
        ys = '0;
        zs = '0;
        if (dl == '0) begin
            if (wl <= 4'd1 || hl == '0) begin
                swz = lin;  // narrow or flat: straight copy
            end else if (wl < hl) begin
                // square blocks stacked vertically
                sb  = wl6 + wl6;
                m   = low_mask(sb);
                r   = lin & m;
                swz = (lin & ~m)
                    | {{(WORK_W - OUT_W){1'b0}}, il2(r & low_mask(wl6), r >> wl6)};
            end else begin
                // square blocks side by side
                swz = ((x >> hl6) << (hl6 + hl6))
                    | {{(WORK_W - OUT_W){1'b0}}, il2(x & low_mask(hl6), y)};
            end
        end else begin
            // 3D Morton, slab height capped at the width when height exceeds width
            sb  = wl6 + he6 + dl6;
            m   = low_mask(sb);
            r   = lin & m;
            xs  = r & low_mask(wl6);
            ys  = (r >> wl6) & low_mask(he6);
            zs  = r >> (wl6 + he6);
            swz = (lin & ~m) | ({{(WORK_W - OUT_W){1'b0}}, il3(xs, ys, zs)} & m);
        end
    end

    assign source_index = cfg.reverse_direction ? swz[OUT_W-1:0] : lin[OUT_W-1:0];
    assign dest_index   = cfg.reverse_direction ? lin[OUT_W-1:0] : swz[OUT_W-1:0];

    always_comb begin
        case (cfg.pixel_size_code)
            msta_pkg::PIX_8:  pixel_out = {56'd0, pixel_in[7:0]};
            msta_pkg::PIX_16: pixel_out = {48'd0, pixel_in[15:0]};
            msta_pkg::PIX_32: pixel_out = {32'd0, pixel_in[31:0]};
            msta_pkg::PIX_64: pixel_out = pixel_in;
            default:          pixel_out = pixel_in;
        endcase
    end

endmodule

>>> rtl/morton_texture_swizzle_address_unit.sv
// ----------------------------------------------------------------------------
// morton_texture_swizzle_address_unit - texel address swizzler
// Maps a texel coordinate to linear and Z-order / Morton element indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one request per texel: coordinate x/y/z and the pixel
//   the copy engine fetched from the previous source index. Result channel
//   (m_*): source and destination element index plus the pixel masked to
//   the configured pixel width. Exactly one result per request, in order.
//   Config channel (cfg_*): index 0..4 = width_log2, height_log2, depth_log2,
//   reverse_direction, pixel_size_code. Always ready; unknown indexes are
//   dropped. Write only while no request is in flight.
//   Path: input register, then address logic into the result register.
//   Throughput: one request per cycle while m_ready is high; the path is bit
//   interleave, shifts and masking between the two register stages.
//   Stall: when m_ready is low the result register holds and the input
//   register fills; s_ready drops only when both stages are occupied.
//   Reset (aresetn low, synchronous): pipeline emptied, config cleared to 0.
// ----------------------------------------------------------------------------
module morton_texture_swizzle_address_unit #(
    parameter int MAX_DIM_LOG2 = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msta_pkg::CFG_DATA_W-1:0]     cfg_data,
    // texel requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [msta_pkg::COORD_W-1:0]        s_coord_x,
    input  logic [msta_pkg::COORD_W-1:0]        s_coord_y,
    input  logic [msta_pkg::COORD_W-1:0]        s_coord_z,
    input  logic [msta_pkg::PIXEL_W-1:0]        s_pixel_in,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [msta_pkg::INDEX_W-1:0]        m_source_index,
    output logic [msta_pkg::INDEX_W-1:0]        m_dest_index,
    output logic [msta_pkg::PIXEL_W-1:0]        m_pixel_out
);

    msta_pkg::cfg_t cfg_reg;

    // input stage
    logic                           in_valid_reg;
    logic [msta_pkg::COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic [msta_pkg::PIXEL_W-1:0]   pixel_reg;

    // result stage
    logic                           out_valid_reg;
    logic [msta_pkg::INDEX_W-1:0]   src_reg, dst_reg;
    logic [msta_pkg::PIXEL_W-1:0]   pix_out_reg;

    logic [msta_pkg::INDEX_W-1:0]   src_next, dst_next;
    logic [msta_pkg::PIXEL_W-1:0]   pix_out_next;

    logic out_free;  // result register can take a new entry
    logic advance;   // input stage moves into result stage
    logic s_fire;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                msta_pkg::REG_WIDTH_LOG2:  cfg_reg.width_log2        <= cfg_data;
                msta_pkg::REG_HEIGHT_LOG2: cfg_reg.height_log2       <= cfg_data;
                msta_pkg::REG_DEPTH_LOG2:  cfg_reg.depth_log2        <= cfg_data;
                msta_pkg::REG_REVERSE:     cfg_reg.reverse_direction <= cfg_data[0];
                msta_pkg::REG_PIXEL_SIZE:  cfg_reg.pixel_size_code   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg     <= s_coord_x;
            y_reg     <= s_coord_y;
            z_reg     <= s_coord_z;
            pixel_reg <= s_pixel_in;
        end
    end

    msta_addr_calc #(
        .MAX_DIM_LOG2 (MAX_DIM_LOG2)
    ) u_calc (
        .cfg          (cfg_reg),
        .coord_x      (x_reg),
        .coord_y      (y_reg),
        .coord_z      (z_reg),
        .pixel_in     (pixel_reg),
        .source_index (src_next),
        .dest_index   (dst_next),
        .pixel_out    (pix_out_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            pix_out_reg <= pix_out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_source_index = src_reg;
    assign m_dest_index   = dst_reg;
    assign m_pixel_out    = pix_out_reg;

endmodule
